// ----- hw/rtl/srsack_pkg.sv -----
`default_nettype none
package srsack_pkg;

	localparam int ROW_BITS = 32;
	localparam int BIT_W = $clog2(ROW_BITS);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_CORRUPT = 2'd1;
	localparam logic [1:0] KIND_FIN = 2'd2;

	localparam logic [2:0] EV_CORRUPT = 3'd0;
	localparam logic [2:0] EV_OUT_OF_WINDOW = 3'd1;
	localparam logic [2:0] EV_IN_ORDER = 3'd2;
	localparam logic [2:0] EV_OUT_OF_ORDER = 3'd3;
	localparam logic [2:0] EV_FIN = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [30:0] seq_number;
		logic [31:0] received_checksum;
		logic [31:0] payload_checksum;
	} srsack_seg_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [30:0] ack_number;
		logic [30:0] sack_number;
		logic        store_enable;
		logic [7:0]  store_slot;
		logic        flush_now;
	} srsack_reply_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] seq;
	} srsack_item_t;

	typedef struct packed {
		logic         vld;
		srsack_item_t item;
	} srsack_qhead_t;

endpackage
`default_nettype wire

// ----- hw/rtl/srsack_front.sv -----
`default_nettype none
module srsack_front (
	input  srsack_pkg::srsack_seg_t  seg,
	input  logic                     seg_valid,
	input  logic                     full,
	output logic                     seg_stall,
	output logic                     push,
	output srsack_pkg::srsack_item_t item
);
	import srsack_pkg::*;

	always_comb begin
		item.seq = seg.seq_number;
		if (seg.cmd) begin
			item.kind = KIND_FIN;
		end else if (seg.received_checksum != seg.payload_checksum) begin
			item.kind = KIND_CORRUPT;
		end else begin
			item.kind = KIND_DATA;
		end
	end

	assign seg_stall = full;
	assign push = seg_valid && !full;

endmodule
`default_nettype wire

// ----- hw/rtl/srsack_queue.sv -----
`default_nettype none
module srsack_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  srsack_pkg::srsack_item_t  push_item,
	input  logic                      pop,
	output srsack_pkg::srsack_qhead_t head,
	output logic                      full
);
	import srsack_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	srsack_item_t     ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head.vld = (cnt_q != '0);
	assign head.item = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/srsack_back.sv -----
`default_nettype none
module srsack_back #(
	parameter int WINDOW_SLOTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  srsack_pkg::srsack_qhead_t head,
	output logic                      pop,
	output logic                      reply_valid,
	input  logic                      reply_stall,
	output srsack_pkg::srsack_reply_t reply
);
	import srsack_pkg::*;

	localparam int ROWS = (WINDOW_SLOTS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam logic [31:0] WIN = 32'(WINDOW_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [31:0]         ne_q;
	logic [31:0]         ackv_q;
	logic [31:0]         wf_q;
	logic [31:0]         wfm1_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ROWS-1:0]     row_vld_q;
	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;
	logic [ROW_W-1:0]    row_q;
	logic [BIT_W-1:0]    bit_q;
	logic [30:0]         seq_q;
	logic [7:0]          slot_q;
	logic                ord_q;
	logic                en_q;
	srsack_reply_t       reply_q;
	logic                reply_vld_q;

	logic                out_free;
	logic                start;
	logic [32:0]         diff;
	logic                in_win;
	logic [ROW_W-1:0]    diff_row;
	logic [ROW_BITS-1:0] row_val;
	logic [ROW_BITS-1:0] new_row;
	logic                was_set;
	logic [CNT_W-1:0]    cnt_new;
	logic                win_full;
	logic [ROW_BITS-1:0] searched;
	logic [ROW_BITS-1:0] holes;
	logic [ROW_BITS-1:0] iso;
	logic                hole_found;
	logic [BIT_W-1:0]    pos;
	logic [31:0]         hole_off;
	logic [31:0]         ne_adv;
	logic [31:0]         ack_adv;
	logic [31:0]         wf_next;
	logic [31:0]         wfm1_next;
	logic                mem_re;
	logic [ROW_W-1:0]    rd_addr;

	logic                emit;
	srsack_reply_t       rep;
	logic                flush;
	logic                adv;
	logic                take_data;
	logic                scan_more;

	assign out_free = !reply_vld_q || !reply_stall;
	assign start = (state_q == ST_IDLE) && head.vld && out_free;
	assign pop = start;

	assign diff = {2'b00, head.item.seq} - {1'b0, wf_q};
	assign in_win = !diff[32] && (diff[31:0] < WIN);
	assign diff_row = diff[ROW_W+BIT_W-1:BIT_W];

	assign row_val = row_vld_q[row_q] ? rd_data_q : '0;
	assign new_row = row_val | (ROW_BITS'(1) << bit_q);
	assign was_set = row_val[bit_q];
	assign cnt_new = cnt_q + CNT_W'(!was_set);
	assign win_full = (cnt_new == CNT_W'(WINDOW_SLOTS));

	// first hole at or after the slot just filled, or from the row start when scanning
	assign searched = (state_q == ST_UPD) ?
		(new_row | ((ROW_BITS'(1) << bit_q) - ROW_BITS'(1))) : row_val;
	assign holes = ~searched;
	assign iso = holes & (~holes + ROW_BITS'(1));
	assign hole_found = |holes;

	always_comb begin
		pos = '0;
		for (int i = 0; i < ROW_BITS; i++) begin
			if (iso[i]) begin
				pos = pos | BIT_W'(i);
			end
		end
	end

	assign hole_off = (32'(row_q) << BIT_W) | 32'(pos);
	assign ne_adv = wf_q + hole_off;
	assign ack_adv = wfm1_q + hole_off;
	assign wf_next = wf_q + WIN;
	assign wfm1_next = wfm1_q + WIN;

	always_comb begin
		emit = 1'b0;
		rep = '0;
		flush = 1'b0;
		adv = 1'b0;
		take_data = 1'b0;
		scan_more = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (head.item.kind)
						KIND_FIN: begin
							emit = 1'b1;
							flush = 1'b1;
							rep.event_res = EV_FIN;
							rep.ack_number = ackv_q[30:0];
							rep.sack_number = ackv_q[30:0];
							rep.flush_now = 1'b1;
						end
						KIND_CORRUPT: begin
							emit = 1'b1;
							rep.event_res = EV_CORRUPT;
							rep.ack_number = ackv_q[30:0];
							rep.sack_number = ackv_q[30:0];
						end
						default: begin
							if (in_win) begin
								take_data = 1'b1;
								state_d = ST_UPD;
							end else begin
								emit = 1'b1;
								rep.event_res = EV_OUT_OF_WINDOW;
								rep.ack_number = ackv_q[30:0];
								rep.sack_number = ackv_q[30:0];
							end
						end
					endcase
				end
			end
			ST_UPD: begin
				rep.sack_number = seq_q;
				rep.store_enable = !was_set;
				rep.store_slot = slot_q;
				if (ord_q && win_full) begin
					emit = 1'b1;
					flush = 1'b1;
					rep.event_res = EV_IN_ORDER;
					rep.ack_number = wfm1_next[30:0];
					rep.flush_now = 1'b1;
					state_d = ST_IDLE;
				end else if (ord_q && hole_found) begin
					emit = 1'b1;
					adv = 1'b1;
					rep.event_res = EV_IN_ORDER;
					rep.ack_number = ack_adv[30:0];
					state_d = ST_IDLE;
				end else if (ord_q) begin
					scan_more = 1'b1;
					state_d = ST_SCAN;
				end else begin
					emit = 1'b1;
					rep.event_res = EV_OUT_OF_ORDER;
					rep.ack_number = ackv_q[30:0];
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				rep.event_res = EV_IN_ORDER;
				rep.ack_number = ack_adv[30:0];
				rep.sack_number = seq_q;
				rep.store_enable = en_q;
				rep.store_slot = slot_q;
				if (hole_found) begin
					emit = 1'b1;
					adv = 1'b1;
					state_d = ST_IDLE;
				end else begin
					scan_more = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mem_re = take_data || scan_more;
	assign rd_addr = take_data ? diff_row : (row_q + ROW_W'(1));

	// fill map, one row of slots per entry
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			mem[row_q] <= new_row;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take_data) begin
			seq_q <= head.item.seq;
			bit_q <= diff[BIT_W-1:0];
			slot_q <= diff[7:0];
			ord_q <= ({1'b0, head.item.seq} == ne_q);
		end
		if (state_q == ST_UPD) begin
			en_q <= !was_set;
		end
		if (emit) begin
			reply_q <= rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ne_q <= 32'd1;
			ackv_q <= '0;
			wf_q <= 32'd1;
			wfm1_q <= '0;
			cnt_q <= '0;
			row_vld_q <= '0;
			row_q <= '0;
			reply_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				reply_vld_q <= 1'b1;
			end else if (!reply_stall) begin
				reply_vld_q <= 1'b0;
			end
			if (take_data) begin
				row_q <= diff_row;
			end else if (scan_more) begin
				row_q <= row_q + ROW_W'(1);
			end
			if (flush) begin
				wf_q <= wf_next;
				wfm1_q <= wfm1_next;
				ne_q <= wf_next;
				ackv_q <= wfm1_next;
				cnt_q <= '0;
				row_vld_q <= '0;
			end else begin
				if (adv) begin
					ne_q <= ne_adv;
					ackv_q <= ack_adv;
				end
				if (state_q == ST_UPD) begin
					cnt_q <= cnt_new;
					row_vld_q[row_q] <= 1'b1;
				end
			end
		end
	end

	assign reply_valid = reply_vld_q;
	assign reply = reply_q;

endmodule
`default_nettype wire

// ----- hw/rtl/selective_repeat_sack_receiver.sv -----
`default_nettype none
// Selective-repeat receiver: checks each segment's checksum and window position,
// marks its slot in a fill map, moves the cumulative ack to the first hole and
// answers with one reply item per segment; the window is flushed when full or on
// fin. Segments enter a two-entry queue at up to one per cycle while it is not
// full. The window engine answers a fin, corrupt or out-of-window segment from
// its idle state; an in-window one passes an update state and, if in order with
// no hole left in its row, a scan state that reads each further 32-slot row of
// the fill map through its single read port in turn, looking for the first hole
// (at most one fewer than the number of rows). The reply sits in an output
// register, so the engine can begin the next segment in the cycle the reply is
// taken. No clearing pass is needed after reset: each map row has a valid flag.
module selective_repeat_sack_receiver #(
	parameter int WINDOW_SLOTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      seg_valid,
	output logic                      seg_stall,
	input  srsack_pkg::srsack_seg_t   seg,
	output logic                      reply_valid,
	input  logic                      reply_stall,
	output srsack_pkg::srsack_reply_t reply
);
	import srsack_pkg::*;

	logic          full;
	logic          push;
	srsack_item_t  push_item;
	logic          pop;
	srsack_qhead_t head;

	srsack_front u_front (
		.seg       (seg),
		.seg_valid (seg_valid),
		.full      (full),
		.seg_stall (seg_stall),
		.push      (push),
		.item      (push_item)
	);

	srsack_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (full)
	);

	srsack_back #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/srsack_checker.sv -----
`default_nettype none
module srsack_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      reply_valid,
	input logic                      reply_stall,
	input srsack_pkg::srsack_reply_t reply
);
	import srsack_pkg::*;

	// a stalled reply item holds
	a_reply_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_stall |=> reply_valid && $stable(reply))
		else $error("reply item changed while stalled");

	a_store_only_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply.store_enable |->
			reply.event_res == EV_IN_ORDER || reply.event_res == EV_OUT_OF_ORDER)
		else $error("store requested for a dropped or fin item");

	a_flush_cause: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply.flush_now |->
			reply.event_res == EV_IN_ORDER || reply.event_res == EV_FIN)
		else $error("flush on an item that cannot complete the window");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && (reply.event_res == EV_CORRUPT ||
			reply.event_res == EV_OUT_OF_WINDOW) |->
			reply.sack_number == reply.ack_number && !reply.store_enable &&
			reply.store_slot == 8'd0 && !reply.flush_now)
		else $error("dropped item with store, slot, flush or stray sack");

	a_fin_fields: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply.event_res == EV_FIN |->
			reply.flush_now && !reply.store_enable &&
			reply.sack_number == reply.ack_number)
		else $error("fin reply fields inconsistent");

endmodule

bind selective_repeat_sack_receiver srsack_checker u_srsack_checker (.*);
`default_nettype wire

// ----- tb/sv/srsack_reply_checker.sv -----
module srsack_reply_checker #(
	parameter int SLOTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      seg_valid,
	input  logic                      seg_stall,
	input  srsack_pkg::srsack_seg_t   seg,
	input  logic                      reply_valid,
	input  logic                      reply_stall,
	input  srsack_pkg::srsack_reply_t reply,
	output int                        mismatches,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import srsack_pkg::*;

	logic [31:0]      next_exp = 32'd1;
	logic [31:0]      win_first = 32'd1;
	logic [SLOTS-1:0] filled = '0;
	int               filled_cnt = 0;
	int               errs = 0;
	srsack_reply_t    due_replies[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic void flush_window();
		filled = '0;
		filled_cnt = 0;
		win_first = win_first + SLOTS;
	endfunction

	function automatic srsack_reply_t next_reply(srsack_seg_t s);
		srsack_reply_t r;
		logic [63:0]   sq;
		logic [63:0]   off;
		logic [63:0]   gap;
		logic [31:0]   ack;
		r = '0;
		sq = 64'(s.seq_number);
		off = sq - 64'(win_first);
		if (s.cmd) begin
			// fin answers with the ack taken before the window moves on
			ack = next_exp - 32'd1;
			r.event_res = EV_FIN;
			r.ack_number = ack[30:0];
			r.sack_number = ack[30:0];
			r.flush_now = 1'b1;
			flush_window();
			next_exp = win_first;
			return r;
		end
		if (s.received_checksum != s.payload_checksum) begin
			r.event_res = EV_CORRUPT;
		end else if (sq < 64'(win_first) || off >= 64'(SLOTS)) begin
			r.event_res = EV_OUT_OF_WINDOW;
		end else begin
			r.store_slot = off[7:0];
			if (!filled[int'(off)]) begin
				filled[int'(off)] = 1'b1;
				filled_cnt++;
				r.store_enable = 1'b1;
			end
			if (sq == 64'(next_exp)) begin
				r.event_res = EV_IN_ORDER;
				// move up to the first hole, stopping at the window end
				gap = 64'(next_exp) - 64'(win_first);
				while (next_exp >= win_first && gap < 64'(SLOTS) && filled[int'(gap)]) begin
					next_exp = next_exp + 32'd1;
					gap = 64'(next_exp) - 64'(win_first);
				end
			end else begin
				r.event_res = EV_OUT_OF_ORDER;
			end
		end
		ack = next_exp - 32'd1;
		r.ack_number = ack[30:0];
		if (r.event_res == EV_IN_ORDER || r.event_res == EV_OUT_OF_ORDER)
			r.sack_number = s.seq_number;
		else
			r.sack_number = ack[30:0];
		if (r.event_res == EV_IN_ORDER && filled_cnt >= SLOTS) begin
			flush_window();
			r.flush_now = 1'b1;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk) begin
		srsack_reply_t want;
		if (arst_n) begin
			if (reply_valid && !reply_stall) begin
				if (due_replies.size() == 0) begin
					$display("%0t ns: reply expected none got %h", $time, reply);
					errs++;
				end else begin
					want = due_replies.pop_front();
					check_field("event_res", 32'(want.event_res), 32'(reply.event_res));
					check_field("ack_number", 32'(want.ack_number), 32'(reply.ack_number));
					check_field("sack_number", 32'(want.sack_number), 32'(reply.sack_number));
					check_field("store_enable", 32'(want.store_enable), 32'(reply.store_enable));
					check_field("store_slot", 32'(want.store_slot), 32'(reply.store_slot));
					check_field("flush_now", 32'(want.flush_now), 32'(reply.flush_now));
				end
			end
			if (seg_valid && !seg_stall)
				due_replies.push_back(next_reply(seg));
		end
		mismatches <= errs;
		pending <= due_replies.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srsack_pkg::*;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_FIN = 1'b1;
	localparam int   WIN = 256;
	localparam int   RANDOM_ITEMS = 1600;
	localparam int   HOLD_START = 1500;
	localparam int   HOLD_CYCLES = 300;
	localparam int   TAIL_CYCLES = 40;
	localparam int   DRAIN_LIMIT = 5000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          seg_valid = 1'b0;
	logic          seg_stall;
	srsack_seg_t   seg = '0;
	logic          reply_valid;
	logic          reply_stall = 1'b0;
	srsack_reply_t reply;
	int            mismatches;
	int            pending;

	int            burst_left = 0;
	int            sent = 0;
	logic [31:0]   win_base = 32'd1;

	always #10 clk = ~clk;

	selective_repeat_sack_receiver u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_valid   (seg_valid),
		.seg_stall   (seg_stall),
		.seg         (seg),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply)
	);

	srsack_reply_checker #(.SLOTS(WIN)) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_valid   (seg_valid),
		.seg_stall   (seg_stall),
		.seg         (seg),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	function automatic srsack_seg_t seg_of(logic c, logic [30:0] sq, logic [31:0] rx,
			logic [31:0] pl);
		srsack_seg_t s;
		s.cmd = c;
		s.seq_number = sq;
		s.received_checksum = rx;
		s.payload_checksum = pl;
		return s;
	endfunction

	function automatic srsack_seg_t good_seg(logic [30:0] sq);
		logic [31:0] ck;
		ck = $urandom;
		return seg_of(CMD_DATA, sq, ck, ck);
	endfunction

	function automatic srsack_seg_t bad_seg(logic [30:0] sq);
		logic [31:0] ck;
		logic [31:0] flip;
		ck = $urandom;
		flip = (32'h1 << $urandom_range(31, 0)) | ($urandom & $urandom);
		return seg_of(CMD_DATA, sq, ck, ck ^ flip);
	endfunction

	// bursts of random length with gaps between them
	task automatic offer(input srsack_seg_t s);
		int gap;
		if (burst_left == 0) begin
			seg_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		seg <= s;
		seg_valid <= 1'b1;
		do @(posedge clk); while (seg_stall);
		sent++;
	endtask

	task automatic noise(input logic [31:0] w, input int dup_off);
		logic [31:0] sq;
		case ($urandom_range(0, 3))
			0: offer(bad_seg(31'(w + $urandom_range(0, WIN - 1))));
			1: begin
				case ($urandom_range(0, 3))
					0: sq = w - 32'd1 - $urandom_range(0, 64);
					1: sq = w + WIN + $urandom_range(0, 64);
					2: sq = $urandom;
					default: sq = 32'd0;
				endcase
				offer(good_seg(31'(sq)));
			end
			2: offer(good_seg(31'(w + dup_off)));
			default: offer(bad_seg(31'($urandom)));
		endcase
	endtask

	initial begin
		int  order[WIN];
		int  i;
		int  j;
		int  k;
		int  tmp;
		int  guard;
		bit  first_full;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window starting at one: order, gaps, duplicates, edges, corruption, then fins and later window edges
		offer(seg_of(CMD_DATA, 31'd1, 32'h1234_5678, 32'h1234_5678));
		offer(good_seg(31'd3));
		offer(good_seg(31'd3));
		offer(good_seg(31'd2));
		offer(good_seg(31'd256));
		offer(good_seg(31'd257));
		offer(good_seg(31'd0));
		offer(seg_of(CMD_DATA, 31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		offer(seg_of(CMD_DATA, 31'd4, 32'h0, 32'hffff_ffff));
		offer(seg_of(CMD_DATA, 31'd4, 32'h0, 32'h0));
		offer(seg_of(CMD_DATA, 31'd5, 32'hffff_ffff, 32'hffff_ffff));
		offer(good_seg(31'd1));
		offer(seg_of(CMD_FIN, 31'h7fff_ffff, 32'h0, 32'hffff_ffff));
		win_base += WIN;
		offer(seg_of(CMD_FIN, 31'd0, 32'hffff_ffff, 32'h0));
		win_base += WIN;
		offer(bad_seg(31'(win_base + WIN - 1)));
		offer(good_seg(31'(win_base)));
		offer(good_seg(31'(win_base + WIN - 1)));
		offer(seg_of(CMD_FIN, 31'd1, 32'h0, 32'h0));
		win_base += WIN;

		first_full = 1'b1;
		k = sent;
		while (sent < k + RANDOM_ITEMS) begin
			if (first_full || $urandom_range(0, 3) == 0) begin
				// whole window, locally reordered, ends in a flush
				first_full = 1'b0;
				for (i = 0; i < WIN; i++)
					order[i] = i;
				for (i = 0; i < WIN; i++) begin
					j = i + $urandom_range(0, (WIN - 1 - i < 7) ? WIN - 1 - i : 7);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (i = 0; i < WIN; i++) begin
					while ($urandom_range(0, 4) == 0)
						noise(win_base, order[$urandom_range(0, (i > 0) ? i - 1 : 0)]);
					offer(good_seg(31'(win_base + order[i])));
				end
			end else begin
				// a few segments near the front, then fin
				repeat ($urandom_range(0, 30)) begin
					if ($urandom_range(0, 4) == 0)
						noise(win_base, $urandom_range(0, WIN - 1));
					else if ($urandom_range(0, 3) == 0)
						offer(good_seg(31'(win_base + $urandom_range(0, WIN - 1))));
					else
						offer(good_seg(31'(win_base + $urandom_range(0, 24))));
				end
				offer(seg_of(CMD_FIN, 31'($urandom), $urandom, $urandom));
			end
			win_base += WIN;
		end
		seg_valid <= 1'b0;

		@(posedge clk);
		guard = 0;
		while (pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver stall pattern, with one long hold-off to back the block up
	initial begin
		int   cyc;
		int   run_left;
		int   mode;
		logic hold;
		cyc = 0;
		run_left = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
				hold = 1'b1;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 3);
					run_left = (mode == 3) ? $urandom_range(1, 25) : $urandom_range(10, 80);
				end
				run_left--;
				case (mode)
					0: hold = 1'b0;
					1: hold = $urandom_range(0, 1);
					2: hold = ($urandom_range(0, 3) == 0);
					default: hold = 1'b1;
				endcase
			end
			reply_stall <= hold;
		end
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
